### hw/rtl/imu_calibrate_scale_remap_top_assert.svh
// Assertion macros for the IMU calibrate, scale and remap block.
`ifndef IMU_CALIBRATE_SCALE_REMAP_TOP_ASSERT_SVH
`define IMU_CALIBRATE_SCALE_REMAP_TOP_ASSERT_SVH

// same-cycle implication
`define ICSR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icsr assertion failed");

// next-cycle implication
`define ICSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icsr assertion failed");

`endif

### hw/rtl/icsr_pkg.sv
// Shared types and constants for the IMU calibrate, scale and remap block.
`timescale 1ns / 1ps

package icsr_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int OUT_FRAC_BITS  = 16;
  localparam int RES_FRAC_BITS  = 24;
  localparam int AVG_FRAC       = 8;
  localparam int SUM_BITS       = 40;
  localparam int COUNT_BITS_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int NUM_AXES       = 6;
  localparam int TRIG_FRAC      = 30;
  localparam logic [29:0] TRIG_Q30 = 30'd759250125;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_W  = SUM_BITS + AVG_FRAC + 2;
  localparam int AVG_W  = DIV_W + 1;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_ORDER,
    REG_GYRO_RES,
    REG_ACC_RES,
    REG_ONE_G,
    REG_CAL_SAMPLES,
    REG_CAL_ACCEL
  } cfg_reg_t;

  localparam logic [4:0]  RST_AXIS_ORDER  = 5'd0;
  localparam logic [31:0] RST_GYRO_RES    = 32'd17873;
  localparam logic [31:0] RST_ACC_RES     = 32'd1024;
  localparam logic [15:0] RST_ONE_G       = 16'd16384;
  localparam logic [15:0] RST_CAL_SAMPLES = 16'd1000;
  localparam logic        RST_CAL_ACCEL   = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MEAS,
    CMD_YAW,
    CMD_MOUT,
    CMD_ACCUM,
    CMD_DIVGO,
    CMD_DIVPUT,
    CMD_ONEG,
    CMD_OFFS,
    CMD_COUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_cal;
    logic is_yaw;
    logic cal_final;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/icsr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module icsr_div #(
  parameter int DVW = 50,
  parameter int DSW = 17
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int CNT_W = $clog2(DVW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVW-1:0]   dvd_r;
  logic [DSW-1:0]   dsr_r;
  logic [DSW-1:0]   rem_r;
  logic [DSW:0]     rem_sh;
  logic [DSW:0]     rem_nxt;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVW-1]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_nxt = ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVW-2:0], ge};
      rem_r <= rem_nxt[DSW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

### hw/rtl/icsr_datapath.sv
// Datapath: config registers, offsets, sums, shared multiplier, mapping, result register.
`timescale 1ns / 1ps

module icsr_datapath import icsr_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dp_cmd_t                     cmd,
  output dp_status_t                  st,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]           cfg_data,
  input  logic                        in_action,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_x_raw,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_y_raw,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_z_raw,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_x_raw,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_y_raw,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_z_raw,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [DATA_W-1:0]    out_gyro_x_out,
  output logic signed [DATA_W-1:0]    out_gyro_y_out,
  output logic signed [DATA_W-1:0]    out_gyro_z_out,
  output logic signed [DATA_W-1:0]    out_acc_x_out,
  output logic signed [DATA_W-1:0]    out_acc_y_out,
  output logic signed [DATA_W-1:0]    out_acc_z_out,
  output logic                        out_calibration_done
);

  localparam int CW = COUNT_BITS;
  localparam int DSW = CW + 1;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam int MEAS_SHIFT = RES_FRAC_BITS - OUT_FRAC_BITS;
  localparam int OFF_SHIFT  = AVG_FRAC + RES_FRAC_BITS - OUT_FRAC_BITS;
  localparam logic signed [PROD_W-1:0] MEAS_HALF = PROD_W'(1) << (MEAS_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] OFF_HALF  = PROD_W'(1) << (OFF_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] YAW_HALF  = PROD_W'(1) << (TRIG_FRAC - 1);
  localparam logic signed [PROD_W-1:0] S32_MAX   = PROD_W'(32'sh7fffffff);
  localparam logic signed [PROD_W-1:0] S32_MIN   = ~S32_MAX;
  localparam logic signed [AVG_W-1:0]  AVG_LIM   =
    AVG_W'(1) << (SAMPLE_BITS - 1 + AVG_FRAC);

  // axis selectors: low bits pick x/y/z, top bit negates
  localparam logic [2:0] SX = 3'd0, SY = 3'd1, SZ = 3'd2;
  localparam logic [2:0] NX = 3'd4, NY = 3'd5, NZ = 3'd6;
  localparam logic [2:0] PERM_MAP [24][3] = '{
    '{SX, SY, SZ}, '{SY, NX, SZ}, '{NX, NY, SZ}, '{NY, SX, SZ},
    '{SX, NY, NZ}, '{SY, SX, NZ}, '{NX, SY, NZ}, '{NY, NX, NZ},
    '{SZ, NY, SX}, '{SY, SZ, SX}, '{NZ, SY, SX}, '{NY, NZ, SX},
    '{SZ, SY, NX}, '{SY, NZ, NX}, '{NZ, NY, NX}, '{NY, SZ, NX},
    '{SZ, SX, SY}, '{NX, SZ, SY}, '{NZ, NX, SY}, '{SX, NZ, SY},
    '{SZ, NX, NY}, '{NX, NZ, NY}, '{NZ, SX, NY}, '{SX, SZ, NY}
  };

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_MAX) r = S32_MAX[DATA_W-1:0];
    else if (v < S32_MIN) r = S32_MIN[DATA_W-1:0];
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] neg32(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v == S32_MIN[DATA_W-1:0]) r = S32_MAX[DATA_W-1:0];
    else r = -v;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick(
    input logic [2:0] s,
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b,
    input logic signed [DATA_W-1:0] c
  );
    logic signed [DATA_W-1:0] v;
    case (s[1:0])
      2'd0:    v = a;
      2'd1:    v = b;
      default: v = c;
    endcase
    return s[2] ? neg32(v) : v;
  endfunction

  // config
  logic [4:0]  axis_order_r;
  logic [31:0] gres_r, ares_r;
  logic [15:0] one_g_r, csamp_r;
  logic        cacc_r;

  // state and working registers
  logic                             act_r;
  logic signed [SAMPLE_BITS-1:0]    raw_r  [NUM_AXES];
  logic signed [DATA_W-1:0]         off_r  [NUM_AXES];
  logic signed [DATA_W-1:0]         corr_r [NUM_AXES];
  logic signed [DATA_W-1:0]         noff_r [NUM_AXES];
  logic signed [SUM_BITS-1:0]       sum_r  [NUM_AXES];
  logic signed [AVG_W-1:0]          avg_r  [NUM_AXES];
  logic signed [PROD_W-1:0]         m_r    [4];
  logic signed [PROD_W-1:0]         prod_r;
  logic [CW-1:0]                    cnt_r;
  logic                             dneg_r;
  logic signed [DATA_W-1:0]         out_r  [NUM_AXES];
  logic                             out_done_r;
  logic                             out_valid_r;

  // combinational
  logic [2:0]               axm, axp, ysel;
  logic [31:0]              res_m;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [AVG_W-1:0]  avg_cl;
  logic [CW-1:0]            tgt;
  logic signed [DIV_W-1:0]  num_c;
  logic [DIV_W-1:0]         mag_c;
  logic                     div_done;
  logic [DIV_W-1:0]         quot;
  logic                     cs_neg, ss_neg;
  logic signed [DATA_W-1:0] mg [3];
  logic signed [DATA_W-1:0] ma [3];
  logic signed [AVG_W-1:0]  one_v, half_v;
  logic signed [AVG_W-1:0]  aadj [3];
  logic                     hit;
  logic                     is_yaw;

  assign axm   = (cmd.idx > 3'd5) ? 3'd0 : cmd.idx;
  assign axp   = cmd.idx - 3'd1;
  assign ysel  = {1'b0, cmd.idx[1:0]} + (cmd.idx[1] ? 3'd1 : 3'd0);
  assign res_m = (axm < 3'd3) ? gres_r : ares_r;

  always_comb begin
    if (avg_r[axm] > AVG_LIM) avg_cl = AVG_LIM;
    else if (avg_r[axm] < -AVG_LIM) avg_cl = -AVG_LIM;
    else avg_cl = avg_r[axm];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      CMD_MEAS: begin
        mul_a = {{(MUL_W-SAMPLE_BITS){raw_r[axm][SAMPLE_BITS-1]}}, raw_r[axm]};
        mul_b = {1'b0, res_m};
      end
      CMD_YAW: begin
        mul_a = {corr_r[ysel][DATA_W-1], corr_r[ysel]};
        mul_b = {3'b000, TRIG_Q30};
      end
      CMD_OFFS: begin
        mul_a = avg_cl[MUL_W-1:0];
        mul_b = {1'b0, res_m};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    if (csamp_r == 16'd0) tgt = CW'(1);
    else if (csamp_r > 16'(CNT_MAX)) tgt = CNT_MAX;
    else tgt = CW'(csamp_r);
  end

  always_comb begin
    num_c = (DIV_W'(sum_r[axm]) <<< (AVG_FRAC + 1)) + DIV_W'(tgt);
    mag_c = num_c[DIV_W-1] ? ~num_c : num_c;
  end

  icsr_div #(
    .DVW (DIV_W),
    .DSW (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == CMD_DIVGO),
    .dividend (mag_c),
    .divisor  ({tgt, 1'b0}),
    .done     (div_done),
    .quotient (quot)
  );

  // first accel axis beyond half a g in magnitude is moved one g toward zero
  always_comb begin
    one_v  = AVG_W'(one_g_r) << AVG_FRAC;
    half_v = AVG_W'(one_g_r) << (AVG_FRAC - 1);
    hit    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      aadj[i] = avg_r[i+3];
      if (!hit) begin
        if (avg_r[i+3] > half_v) begin
          aadj[i] = avg_r[i+3] - one_v;
          hit     = 1'b1;
        end else if (avg_r[i+3] < -half_v) begin
          aadj[i] = avg_r[i+3] + one_v;
          hit     = 1'b1;
        end
      end
    end
  end

  assign is_yaw = (axis_order_r >= 5'd24) && (axis_order_r < 5'd28);
  assign cs_neg = (axis_order_r == 5'd25) || (axis_order_r == 5'd26);
  assign ss_neg = (axis_order_r == 5'd26) || (axis_order_r == 5'd27);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mg[i] = corr_r[i];
      ma[i] = corr_r[i+3];
    end
    if (axis_order_r < 5'd24) begin
      for (int i = 0; i < 3; i++) begin
        mg[i] = pick(PERM_MAP[axis_order_r][i], corr_r[0], corr_r[1], corr_r[2]);
        ma[i] = pick(PERM_MAP[axis_order_r][i], corr_r[3], corr_r[4], corr_r[5]);
      end
    end else if (is_yaw) begin
      mg[0] = sat32(((cs_neg ? -m_r[0] : m_r[0]) + (ss_neg ? -m_r[1] : m_r[1])
                     + YAW_HALF) >>> TRIG_FRAC);
      mg[1] = sat32(((ss_neg ? m_r[0] : -m_r[0]) + (cs_neg ? -m_r[1] : m_r[1])
                     + YAW_HALF) >>> TRIG_FRAC);
      ma[0] = sat32(((cs_neg ? -m_r[2] : m_r[2]) + (ss_neg ? -m_r[3] : m_r[3])
                     + YAW_HALF) >>> TRIG_FRAC);
      ma[1] = sat32(((ss_neg ? m_r[2] : -m_r[2]) + (cs_neg ? -m_r[3] : m_r[3])
                     + YAW_HALF) >>> TRIG_FRAC);
    end
  end

  // control state, config, calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_order_r <= RST_AXIS_ORDER;
      gres_r       <= RST_GYRO_RES;
      ares_r       <= RST_ACC_RES;
      one_g_r      <= RST_ONE_G;
      csamp_r      <= RST_CAL_SAMPLES;
      cacc_r       <= RST_CAL_ACCEL;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        off_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_AXIS_ORDER:  axis_order_r <= cfg_data[4:0];
          REG_GYRO_RES:    gres_r       <= cfg_data;
          REG_ACC_RES:     ares_r       <= cfg_data;
          REG_ONE_G:       one_g_r      <= cfg_data[15:0];
          REG_CAL_SAMPLES: csamp_r      <= cfg_data[15:0];
          REG_CAL_ACCEL:   cacc_r       <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.op == CMD_ACCUM) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          sum_r[i] <= sum_r[i] + SUM_BITS'(raw_r[i]);
        end
        if (cnt_r != CNT_MAX) cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.op == CMD_COUT) begin
        for (int i = 0; i < 3; i++) begin
          off_r[i] <= noff_r[i];
          if (cacc_r) off_r[i+3] <= noff_r[i+3];
        end
        for (int i = 0; i < NUM_AXES; i++) begin
          sum_r[i] <= '0;
        end
        cnt_r <= '0;
      end
      if ((cmd.op == CMD_MOUT) || (cmd.op == CMD_COUT)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    unique case (cmd.op)
      CMD_LOAD: begin
        act_r    <= in_action;
        raw_r[0] <= in_gyro_x_raw;
        raw_r[1] <= in_gyro_y_raw;
        raw_r[2] <= in_gyro_z_raw;
        raw_r[3] <= in_acc_x_raw;
        raw_r[4] <= in_acc_y_raw;
        raw_r[5] <= in_acc_z_raw;
      end
      CMD_MEAS: begin
        if (cmd.idx != 3'd0) begin
          corr_r[axp] <= sat32(((prod_r + MEAS_HALF) >>> MEAS_SHIFT)
                               - PROD_W'(off_r[axp]));
        end
      end
      CMD_YAW: begin
        if (cmd.idx != 3'd0) m_r[axp[1:0]] <= prod_r;
      end
      CMD_DIVGO: dneg_r <= num_c[DIV_W-1];
      CMD_DIVPUT: avg_r[axm] <= dneg_r ? ~{1'b0, quot} : {1'b0, quot};
      CMD_ONEG: begin
        for (int i = 0; i < 3; i++) begin
          avg_r[i+3] <= aadj[i];
        end
      end
      CMD_OFFS: begin
        if (cmd.idx != 3'd0) begin
          noff_r[axp] <= sat32((prod_r + OFF_HALF) >>> OFF_SHIFT);
        end
      end
      CMD_MOUT: begin
        for (int i = 0; i < 3; i++) begin
          out_r[i]   <= mg[i];
          out_r[i+3] <= ma[i];
        end
        out_done_r <= 1'b0;
      end
      CMD_COUT: begin
        for (int i = 0; i < 3; i++) begin
          out_r[i]   <= noff_r[i];
          out_r[i+3] <= cacc_r ? noff_r[i+3] : off_r[i+3];
        end
        out_done_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign st.is_cal    = act_r;
  assign st.is_yaw    = is_yaw;
  assign st.cal_final = (cnt_r >= tgt);
  assign st.div_done  = div_done;
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_gyro_x_out       = out_r[0];
  assign out_gyro_y_out       = out_r[1];
  assign out_gyro_z_out       = out_r[2];
  assign out_acc_x_out        = out_r[3];
  assign out_acc_y_out        = out_r[4];
  assign out_acc_z_out        = out_r[5];
  assign out_calibration_done = out_done_r;

endmodule

### hw/rtl/icsr_ctrl.sv
// Controller: sequences measure and calibration requests through the datapath.
`timescale 1ns / 1ps

module icsr_ctrl import icsr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] MEAS_LAST = 3'd6;
  localparam logic [2:0] YAW_LAST  = 3'd4;
  localparam logic [2:0] AXIS_LAST = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_MEAS, S_YAW, S_MOUT, S_ACC, S_CHK,
    S_DGO, S_DWAIT, S_DPUT, S_ONEG, S_OFFS, S_COUT
  } state_t;

  state_t     state_r;
  logic [2:0] cnt_r;

  always_comb begin
    cmd.op  = CMD_NONE;
    cmd.idx = cnt_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) cmd.op = CMD_LOAD;
      S_MEAS:  cmd.op = CMD_MEAS;
      S_YAW:   cmd.op = CMD_YAW;
      S_MOUT:  if (st.out_free) cmd.op = CMD_MOUT;
      S_ACC:   cmd.op = CMD_ACCUM;
      S_DGO:   cmd.op = CMD_DIVGO;
      S_DPUT:  cmd.op = CMD_DIVPUT;
      S_ONEG:  cmd.op = CMD_ONEG;
      S_OFFS:  cmd.op = CMD_OFFS;
      S_COUT:  if (st.out_free) cmd.op = CMD_COUT;
      S_DISP, S_CHK, S_DWAIT: cmd.op = CMD_NONE;
      default: cmd.op = CMD_NONE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_DISP;
        S_DISP: begin
          cnt_r   <= '0;
          state_r <= st.is_cal ? S_ACC : S_MEAS;
        end
        S_MEAS: begin
          if (cnt_r == MEAS_LAST) begin
            cnt_r   <= '0;
            state_r <= st.is_yaw ? S_YAW : S_MOUT;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_YAW: begin
          if (cnt_r == YAW_LAST) begin
            cnt_r   <= '0;
            state_r <= S_MOUT;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_MOUT: if (st.out_free) state_r <= S_IDLE;
        S_ACC:  state_r <= S_CHK;
        S_CHK: begin
          cnt_r   <= '0;
          state_r <= st.cal_final ? S_DGO : S_IDLE;
        end
        S_DGO:   state_r <= S_DWAIT;
        S_DWAIT: if (st.div_done) state_r <= S_DPUT;
        S_DPUT: begin
          if (cnt_r == AXIS_LAST) begin
            cnt_r   <= '0;
            state_r <= S_ONEG;
          end else begin
            cnt_r   <= cnt_r + 3'd1;
            state_r <= S_DGO;
          end
        end
        S_ONEG: begin
          cnt_r   <= '0;
          state_r <= S_OFFS;
        end
        S_OFFS: begin
          if (cnt_r == MEAS_LAST) begin
            cnt_r   <= '0;
            state_r <= S_COUT;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_COUT: if (st.out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/imu_calibrate_scale_remap_top.sv
// Top level of the IMU calibrate, scale and remap block.
`timescale 1ns / 1ps

// Takes one request at a time. A measure request is paced by the single
// shared multiplier that handles the six axes and, with a yaw orientation,
// the four yaw products in turn. The final calibration sample averages the
// six sums through a one-bit-per-cycle divider, one axis after another,
// then scales the offsets. The result register lets the next request start
// while a result waits.
module imu_calibrate_scale_remap_top import icsr_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [DATA_W-1:0]             cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_x_raw,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_y_raw,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_z_raw,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_x_raw,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_y_raw,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_z_raw,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_W-1:0]      out_gyro_x_out,
  output logic signed [DATA_W-1:0]      out_gyro_y_out,
  output logic signed [DATA_W-1:0]      out_gyro_z_out,
  output logic signed [DATA_W-1:0]      out_acc_x_out,
  output logic signed [DATA_W-1:0]      out_acc_y_out,
  output logic signed [DATA_W-1:0]      out_acc_z_out,
  output logic                          out_calibration_done
);

  dp_cmd_t    cmd;
  dp_status_t st;

  icsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  icsr_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_action            (in_action),
    .in_gyro_x_raw        (in_gyro_x_raw),
    .in_gyro_y_raw        (in_gyro_y_raw),
    .in_gyro_z_raw        (in_gyro_z_raw),
    .in_acc_x_raw         (in_acc_x_raw),
    .in_acc_y_raw         (in_acc_y_raw),
    .in_acc_z_raw         (in_acc_z_raw),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_gyro_x_out       (out_gyro_x_out),
    .out_gyro_y_out       (out_gyro_y_out),
    .out_gyro_z_out       (out_gyro_z_out),
    .out_acc_x_out        (out_acc_x_out),
    .out_acc_y_out        (out_acc_y_out),
    .out_acc_z_out        (out_acc_z_out),
    .out_calibration_done (out_calibration_done)
  );

`include "imu_calibrate_scale_remap_top_assert.svh"

  `ICSR_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  `ICSR_ASSERT_SAME(a_div_only_busy, st.div_done, !in_ready)
  `ICSR_ASSERT_SAME(a_res_from_busy, $rose(out_valid), !$past(in_ready))

endmodule

### tb/imu_calibrate_scale_remap_top_tb.sv
// Self-checking testbench for the IMU calibrate, scale and remap block.
`timescale 1ns / 1ps

module imu_calibrate_scale_remap_top_tb;
  import icsr_pkg::*;

  typedef struct packed {
    logic             action;
    logic [5:0][15:0] raw;
  } imu_req_t;

  typedef struct packed {
    logic [5:0][31:0] val;
    logic             done;
  } imu_res_t;

  typedef struct packed {
    logic             is_cfg;
    cfg_reg_t         idx;
    logic [31:0]      cdata;
    imu_req_t         req;
    logic             typed;
    logic [5:0][31:0] tval;
  } dir_row_t;

  localparam logic ACT_MEASURE = 1'b0;
  localparam logic ACT_CAL     = 1'b1;
  localparam int   WDOG_LIMIT  = 5000;
  localparam int   SETTLE      = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic signed [15:0] in_raw [6];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_val [6];
  logic out_calibration_done;

  initial for (int i = 0; i < 6; i++) in_raw[i] = '0;

  imu_calibrate_scale_remap_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_gyro_x_raw(in_raw[0]), .in_gyro_y_raw(in_raw[1]), .in_gyro_z_raw(in_raw[2]),
    .in_acc_x_raw(in_raw[3]), .in_acc_y_raw(in_raw[4]), .in_acc_z_raw(in_raw[5]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_gyro_x_out(out_val[0]), .out_gyro_y_out(out_val[1]), .out_gyro_z_out(out_val[2]),
    .out_acc_x_out(out_val[3]), .out_acc_y_out(out_val[4]), .out_acc_z_out(out_val[5]),
    .out_calibration_done(out_calibration_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow configuration and state
  logic [4:0]  sh_axis;
  logic [31:0] sh_gres, sh_ares;
  logic [15:0] sh_one_g, sh_samples;
  logic        sh_cal_acc;
  logic [39:0] gyro_sum [3], acc_sum [3];
  logic [15:0] taken;
  longint      gyro_off [3], acc_off [3];
  int          perm_sel [24][3];

  imu_res_t offsets_q [$];
  int       fails = 0;
  int       idle_mode = 0;
  int       quiet = 0;

  function automatic longint sat32(longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  function automatic longint round_to_q16(longint v, int frac_in);
    int s;
    s = frac_in - OUT_FRAC_BITS;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [2:0][31:0] remap(input logic [2:0][63:0] v);
    logic [2:0][31:0] o;
    longint x, y, c, s;
    int sel, code;
    code = sh_axis;
    if (code < 24) begin
      for (int i = 0; i < 3; i++) begin
        sel = perm_sel[code][i];
        x = v[(sel < 0 ? -sel : sel) - 1];
        o[i] = sat32(sel < 0 ? -x : x);
      end
    end else if (code < 28) begin
      x = v[0];
      y = v[1];
      c = (code == 24 || code == 27) ? 64'sd759250125 : -64'sd759250125;
      s = (code == 24 || code == 25) ? 64'sd759250125 : -64'sd759250125;
      o[0] = sat32((x * c + y * s + (64'sd1 <<< 29)) >>> 30);
      o[1] = sat32((-x * s + y * c + (64'sd1 <<< 29)) >>> 30);
      o[2] = v[2];
    end else begin
      for (int i = 0; i < 3; i++) o[i] = v[i];
    end
    return o;
  endfunction

  function automatic longint sum_average(logic [39:0] sum, longint n);
    longint a, b, q;
    a = 2 * ({{24{sum[39]}}, sum} * 256) + n;
    b = 2 * n;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint avg_offset(longint avg, logic [31:0] res);
    longint lim;
    lim = 64'sd1 <<< (SAMPLE_BITS - 1 + AVG_FRAC);
    if (avg < -lim) avg = -lim;
    if (avg > lim) avg = lim;
    return sat32(round_to_q16(avg * longint'({32'd0, res}), AVG_FRAC + RES_FRAC_BITS));
  endfunction

  function automatic bit imu_predict(input imu_req_t r, output imu_res_t res);
    logic [2:0][63:0] gv, av;
    logic [2:0][31:0] gm, am;
    longint rv, n, one, half;
    longint ga [3], aa [3];
    res = '0;
    if (r.action == ACT_MEASURE) begin
      for (int i = 0; i < 3; i++) begin
        rv = longint'(signed'(r.raw[i]));
        gv[i] = sat32(round_to_q16(rv * longint'({32'd0, sh_gres}), RES_FRAC_BITS)
                      - gyro_off[i]);
        rv = longint'(signed'(r.raw[3 + i]));
        av[i] = sat32(round_to_q16(rv * longint'({32'd0, sh_ares}), RES_FRAC_BITS)
                      - acc_off[i]);
      end
      gm = remap(gv);
      am = remap(av);
      for (int i = 0; i < 3; i++) begin
        res.val[i] = gm[i];
        res.val[3 + i] = am[i];
      end
      return 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      gyro_sum[i] = gyro_sum[i] + {{24{r.raw[i][15]}}, r.raw[i]};
      acc_sum[i] = acc_sum[i] + {{24{r.raw[3 + i][15]}}, r.raw[3 + i]};
    end
    if (taken != 16'hFFFF) taken++;
    n = (sh_samples == 0) ? 1 : sh_samples;
    if (taken < n) return 1'b0;
    one = longint'(sh_one_g) <<< AVG_FRAC;
    half = longint'(sh_one_g) <<< (AVG_FRAC - 1);
    for (int i = 0; i < 3; i++) begin
      ga[i] = sum_average(gyro_sum[i], n);
      aa[i] = sum_average(acc_sum[i], n);
    end
    for (int i = 0; i < 3; i++) begin
      if (aa[i] > half) begin
        aa[i] -= one;
        break;
      end
      if (aa[i] < -half) begin
        aa[i] += one;
        break;
      end
    end
    for (int i = 0; i < 3; i++) begin
      gyro_off[i] = avg_offset(ga[i], sh_gres);
      if (sh_cal_acc) acc_off[i] = avg_offset(aa[i], sh_ares);
      gyro_sum[i] = '0;
      acc_sum[i] = '0;
      res.val[i] = gyro_off[i];
      res.val[3 + i] = acc_off[i];
    end
    taken = '0;
    res.done = 1'b1;
    return 1'b1;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_AXIS_ORDER:  sh_axis = v[4:0];
      REG_GYRO_RES:    sh_gres = v;
      REG_ACC_RES:     sh_ares = v;
      REG_ONE_G:       sh_one_g = v[15:0];
      REG_CAL_SAMPLES: sh_samples = v[15:0];
      REG_CAL_ACCEL:   sh_cal_acc = v[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (offsets_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // typed expectation overrides the predicted value when given
  task automatic send_req(imu_req_t r, bit typed, logic [5:0][31:0] tval);
    imu_res_t res;
    int p;
    p = (idle_mode == 1) ? 65 : (idle_mode == 3) ? 23 : 0;
    if (p != 0 && $urandom_range(99) < p) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < p) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= r.action;
    for (int i = 0; i < 6; i++) in_raw[i] <= r.raw[i];
    do @(posedge clk); while (!in_ready);
    if (imu_predict(r, res)) begin
      if (typed) res.val = tval;
      offsets_q.push_back(res);
    end
  endtask

  function automatic logic [15:0] rand_raw(bit accel);
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return accel ? sh_one_g + $urandom_range(255) - 128 : $urandom_range(15);
      4: return accel ? -sh_one_g : $urandom_range(65535);
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic logic [31:0] rand_res();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd17873;
      3: return 32'd1024;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_one_g();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return $urandom_range(65535);
      default: return 16'd16384;
    endcase
  endfunction

  // result side: stall as the phase asks, check each accepted result
  always @(posedge clk) begin
    int p;
    imu_res_t e;
    if (out_valid && out_ready) begin
      if (offsets_q.size() == 0) begin
        $display("%0t result with nothing expected: gx %h done %b", $time,
                 out_val[0], out_calibration_done);
        fails++;
      end else begin
        e = offsets_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (out_val[i] !== e.val[i]) begin
            $display("%0t field %0d mismatch: expected %h actual %h", $time, i,
                     e.val[i], out_val[i]);
            fails++;
          end
        if (out_calibration_done !== e.done) begin
          $display("%0t calibration_done mismatch: expected %b actual %b", $time,
                   e.done, out_calibration_done);
          fails++;
        end
      end
    end
    p = (idle_mode == 2) ? 65 : (idle_mode == 3) ? 23 : 0;
    out_ready <= ($urandom_range(99) >= p);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  dir_row_t dir_rows [$];

  task automatic add_cfg(cfg_reg_t idx, logic [31:0] v);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.cdata = v;
    dir_rows.push_back(row);
  endtask

  task automatic add_req(logic act, logic [5:0][15:0] raw, bit typed,
                         logic [5:0][31:0] tval);
    dir_row_t row;
    row = '0;
    row.req.action = act;
    row.req.raw = raw;
    row.typed = typed;
    row.tval = tval;
    dir_rows.push_back(row);
  endtask

  initial begin
    imu_req_t r;
    logic [5:0][31:0] none;
    perm_sel = '{'{1, 2, 3}, '{2, -1, 3}, '{-1, -2, 3}, '{-2, 1, 3},
                 '{1, -2, -3}, '{2, 1, -3}, '{-1, 2, -3}, '{-2, -1, -3},
                 '{3, -2, 1}, '{2, 3, 1}, '{-3, 2, 1}, '{-2, -3, 1},
                 '{3, 2, -1}, '{2, -3, -1}, '{-3, -2, -1}, '{-2, 3, -1},
                 '{3, 1, 2}, '{-1, 3, 2}, '{-3, -1, 2}, '{1, -3, 2},
                 '{3, -1, -2}, '{-1, -3, -2}, '{-3, 1, -2}, '{1, 3, -2}};
    sh_axis = RST_AXIS_ORDER;
    sh_gres = RST_GYRO_RES;
    sh_ares = RST_ACC_RES;
    sh_one_g = RST_ONE_G;
    sh_samples = RST_CAL_SAMPLES;
    sh_cal_acc = RST_CAL_ACCEL;
    taken = '0;
    for (int i = 0; i < 3; i++) begin
      gyro_sum[i] = '0;
      acc_sum[i] = '0;
      gyro_off[i] = 0;
      acc_off[i] = 0;
    end
    none = '0;

    // after reset, extremes at reset and extreme resolutions
    add_req(ACT_MEASURE, '0, 1, '0);
    add_req(ACT_MEASURE, {6{16'h7FFF}}, 1, {{3{32'd131068}}, {3{32'd2287674}}});
    add_req(ACT_MEASURE, {6{16'h8000}}, 1, {{3{-32'sd131072}}, {3{-32'sd2287744}}});
    add_cfg(REG_GYRO_RES, 32'hFFFF_FFFF);
    add_cfg(REG_ACC_RES, 32'hFFFF_FFFF);
    add_req(ACT_MEASURE, {6{16'h7FFF}}, 1, {6{32'h7FFF_FFFF}});
    add_req(ACT_MEASURE, {6{16'h8000}}, 1, {6{32'h8000_0000}});
    add_cfg(REG_GYRO_RES, 32'h0);
    add_cfg(REG_ACC_RES, 32'h0);
    add_req(ACT_MEASURE, {6{16'h7FFF}}, 1, '0);
    add_cfg(REG_GYRO_RES, 32'd17873);
    add_cfg(REG_ACC_RES, 32'd1024);
    // zero sample target finishes on the first sample
    add_cfg(REG_CAL_SAMPLES, 32'd0);
    add_req(ACT_CAL, {16'd16384, -16'sd60, 16'd50, 16'd300, -16'sd200, 16'd100}, 0, none);
    add_req(ACT_MEASURE, {16'd16000, 16'd9, -16'sd7, 16'd1000, 16'd2000, -16'sd3000},
            0, none);
    for (int k = 0; k < 8; k++) begin
      add_cfg(REG_AXIS_ORDER, (k < 6) ? 5 + k * 4 - (k > 4 ? 1 : 0) : 28 + (k - 6) * 3);
      add_req(ACT_MEASURE, {16'h7FFF, 16'h8000, 16'd12345, 16'h8000, 16'h7FFF, -16'sd4321},
              0, none);
    end
    for (int k = 24; k < 28; k++) begin
      add_cfg(REG_AXIS_ORDER, k);
      add_req(ACT_MEASURE, {16'h7FFF, 16'h8000, 16'd12345, 16'h8000, 16'h7FFF, -16'sd4321},
              0, none);
    end
    // accel offsets kept off, zero one_g
    add_cfg(REG_AXIS_ORDER, 32'd0);
    add_cfg(REG_CAL_ACCEL, 32'd0);
    add_cfg(REG_ONE_G, 32'd0);
    add_cfg(REG_CAL_SAMPLES, 32'd3);
    for (int k = 0; k < 3; k++)
      add_req(ACT_CAL, {16'h7FFF, 16'h8000, 16'd500, 16'd10, -16'sd20, 16'd30}, 0, none);
    // target lowered mid-run; negative half g on y
    add_cfg(REG_CAL_ACCEL, 32'd1);
    add_cfg(REG_ONE_G, 32'd16384);
    add_cfg(REG_CAL_SAMPLES, 32'd8);
    for (int k = 0; k < 3; k++)
      add_req(ACT_CAL, {16'd100, -16'sd20000, 16'd40, 16'd7, 16'd8, 16'd9}, 0, none);
    add_cfg(REG_CAL_SAMPLES, 32'd2);
    add_req(ACT_CAL, {16'd100, -16'sd20000, 16'd40, 16'd7, 16'd8, 16'd9}, 0, none);
    // measure in the middle of a calibration
    add_cfg(REG_CAL_SAMPLES, 32'd2);
    add_req(ACT_CAL, {16'd300, 16'd200, 16'd100, -16'sd5, 16'd5, -16'sd5}, 0, none);
    add_req(ACT_MEASURE, {16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6}, 0, none);
    add_req(ACT_CAL, {16'd300, 16'd200, 16'd100, -16'sd5, 16'd5, -16'sd5}, 0, none);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].cdata);
      end else begin
        send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].tval);
      end
    end

    for (int ph = 0; ph < 16; ph++) begin
      wait_idle();
      idle_mode = ph / 4;
      write_reg(REG_AXIS_ORDER, (ph % 5 == 0) ? 31 : (ph % 5 == 1) ? 0 : $urandom_range(31));
      write_reg(REG_GYRO_RES, rand_res());
      write_reg(REG_ACC_RES, rand_res());
      write_reg(REG_ONE_G, rand_one_g());
      write_reg(REG_CAL_SAMPLES, ($urandom_range(15) == 0) ? 16'hFFFF : $urandom_range(6));
      write_reg(REG_CAL_ACCEL, $urandom_range(1));
      for (int n = 0; n < 75; n++) begin
        r.action = ($urandom_range(99) < 35) ? ACT_CAL : ACT_MEASURE;
        for (int i = 0; i < 6; i++) r.raw[i] = rand_raw(i >= 3);
        send_req(r, 0, none);
      end
    end

    in_valid <= 1'b0;
    while (offsets_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
